// ===== hdl/absc_pkg.sv =====
package absc_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int KEY_TOP_W  = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_A_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_A_MID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_A_TOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_B_LOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_B_TOP = 3'd4;

	// Key state widths and wrap points
	localparam int KEY_NUM_W = 7;
	localparam int POS_A_W   = 5;
	localparam int POS_B_W   = 4;
	localparam int POS_A_MAX = 19;
	localparam int POS_B_MAX = 11;

	// Remainder unit
	localparam int REM_W = 4;

	// Reciprocal pairs: (x * MUL) >> SH gives x / d for every 7-bit x
	localparam logic [7:0] MUL_9  = 8'd57;
	localparam logic [3:0] SH_9   = 4'd9;
	localparam logic [7:0] MUL_12 = 8'd86;
	localparam logic [3:0] SH_12  = 4'd10;
	localparam logic [7:0] MUL_5  = 8'd103;
	localparam logic [3:0] SH_5   = 4'd9;
	localparam logic [7:0] MUL_15 = 8'd137;
	localparam logic [3:0] SH_15  = 4'd11;
	localparam logic [7:0] MUL_7  = 8'd147;
	localparam logic [3:0] SH_7   = 4'd10;

	// Controller to datapath
	typedef struct packed {
		logic cap;
		logic xform;
		logic div_go;
	} absc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_free;
	} absc_sts_t;

endpackage

// ===== hdl/absc_if.sv =====
interface absc_in_if;
	logic        valid;
	logic        ready;
	logic        start_req;
	logic [31:0] file_size;
	logic [7:0]  data_in;
	logic        mode;

	modport source (output valid, output start_req, output file_size, output data_in,
		output mode, input ready);
	modport sink (input valid, input start_req, input file_size, input data_in,
		input mode, output ready);
endinterface

interface absc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;

	modport source (output valid, output data_out, input ready);
	modport sink (input valid, input data_out, output ready);
endinterface

// ===== hdl/absc_ctrl.sv =====
module absc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_start,
	output logic               in_ready,
	output absc_pkg::absc_cmd_t cmd,
	input  absc_pkg::absc_sts_t sts
);
	import absc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEED_A,
		S_XFORM
	} state_t;

	state_t state_q;
	logic   div_go_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;

	assign cmd.cap    = accept;
	assign cmd.xform  = (state_q == S_XFORM) & sts.out_free;
	assign cmd.div_go = div_go_q;

	// Sequence seeding and transform
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_start) begin
							state_q  <= S_SEED_A;
							div_go_q <= 1'b1;
						end else begin
							state_q <= S_XFORM;
						end
					end
				end
				S_SEED_A: begin
					if (sts.div_done) state_q <= S_XFORM;
				end
				S_XFORM: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/absc_dp.sv =====
module absc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  absc_pkg::absc_cmd_t               cmd,
	output absc_pkg::absc_sts_t               sts,
	input  logic                              start_req,
	input  logic [31:0]                       file_size,
	input  logic [7:0]                        data_in,
	input  logic                              mode,
	input  logic                              cfg_we,
	input  logic [absc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [absc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        data_out
);
	import absc_pkg::*;

	// Key registers
	logic [63:0]          key_a_low_q, key_a_mid_q, key_b_low_q;
	logic [KEY_TOP_W-1:0] key_a_top_q, key_b_top_q;
	logic [151:0]         key_a_all;
	logic [87:0]          key_b_all;

	// Key state
	logic [KEY_NUM_W-1:0] key_num_q;
	logic [POS_A_W-1:0]   pos_a_q;
	logic [POS_B_W-1:0]   pos_b_q;
	logic                 swap_q;
	logic [KEY_NUM_W-1:0] key_num_inc;

	// Captured item and result
	logic [7:0] data_q;
	logic       mode_q;
	logic       out_valid_q;
	logic [7:0] data_out_q;

	// Remainder unit for the seed, whose divisor is position B
	logic                 div_busy_q;
	logic [2:0]           div_cnt_q;
	logic [KEY_NUM_W-1:0] div_dvd_q;
	logic [REM_W-1:0]     div_dsr_q;
	logic [REM_W-1:0]     div_rem_q;
	logic [REM_W:0]       div_trial;
	logic [REM_W-1:0]     div_rem_next;
	logic                 div_done;

	// Transform
	logic [7:0]         ka, kb_raw, kb, stage1, stage2, result;
	logic [POS_A_W-1:0] next_a;
	logic [POS_B_W:0]   next_b;
	logic               wrap_a, wrap_b, dbl_wrap;

	// Remainder by a fixed divisor through its reciprocal
	function automatic logic [REM_W-1:0] mod_const(logic [KEY_NUM_W-1:0] x,
		logic [7:0] mul, logic [3:0] sh, logic [REM_W-1:0] dsr);
		logic [14:0]          prod;
		logic [KEY_NUM_W-1:0] quo;
		logic [10:0]          back;
		prod = {8'b0, x} * {7'b0, mul};
		quo  = KEY_NUM_W'(prod >> sh);
		back = {4'b0, quo} * {7'b0, dsr};
		return REM_W'(x - back[KEY_NUM_W-1:0]);
	endfunction

	assign key_a_all = {key_a_top_q, key_a_mid_q, key_a_low_q};
	assign key_b_all = {key_b_top_q, key_b_low_q};

	// Pick key bytes by position; positions outside the tables give zero
	always_comb begin
		ka     = 8'h00;
		kb_raw = 8'h00;
		if (pos_a_q >= 5'd1 && pos_a_q <= 5'(POS_A_MAX))
			ka = key_a_all[{5'(pos_a_q - 5'd1), 3'b000} +: 8];
		if (pos_b_q >= 4'd1 && pos_b_q <= 4'(POS_B_MAX))
			kb_raw = key_b_all[{4'(pos_b_q - 4'd1), 3'b000} +: 8];
	end

	assign kb = kb_raw ^ {1'b0, key_num_q};

	// Encrypt runs key A first, decrypt runs key B first
	assign stage1 = data_q ^ (mode_q ? ka : kb);
	assign stage2 = swap_q ? {stage1[3:0], stage1[7:4]} : stage1;
	assign result = stage2 ^ (mode_q ? kb : ka);

	// Advance positions
	assign next_a      = pos_a_q + 5'd1;
	assign next_b      = {1'b0, pos_b_q} + 5'd1;
	assign wrap_a      = next_a > 5'(POS_A_MAX);
	assign wrap_b      = next_b > 5'(POS_B_MAX);
	assign dbl_wrap    = wrap_a & wrap_b;
	assign key_num_inc = key_num_q + 7'd1;

	// Remainder step: shift in one dividend bit, subtract if it fits
	assign div_trial    = {div_rem_q, div_dvd_q[KEY_NUM_W-1]};
	assign div_rem_next = (div_trial >= {1'b0, div_dsr_q}) ?
		REM_W'(div_trial - {1'b0, div_dsr_q}) : div_trial[REM_W-1:0];
	assign div_done     = div_busy_q & (div_cnt_q == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= 3'd0;
		end else if (cmd.div_go) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= 3'(KEY_NUM_W - 1);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 3'd1;
			if (div_cnt_q == 3'd0) div_busy_q <= 1'b0;
		end
	end

	// Remainder operands need no reset
	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			div_dvd_q <= key_num_q;
			div_dsr_q <= pos_b_q;
			div_rem_q <= '0;
		end else if (div_busy_q) begin
			div_dvd_q <= {div_dvd_q[KEY_NUM_W-2:0], 1'b0};
			div_rem_q <= div_rem_next;
		end
	end

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_low_q <= '0;
			key_a_mid_q <= '0;
			key_a_top_q <= '0;
			key_b_low_q <= '0;
			key_b_top_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_A_LOW: key_a_low_q <= cfg_data;
				CFG_KEY_A_MID: key_a_mid_q <= cfg_data;
				CFG_KEY_A_TOP: key_a_top_q <= cfg_data[KEY_TOP_W-1:0];
				CFG_KEY_B_LOW: key_b_low_q <= cfg_data;
				CFG_KEY_B_TOP: key_b_top_q <= cfg_data[KEY_TOP_W-1:0];
				default: ;
			endcase
		end
	end

	// Key state: seed on start, step after each byte, reseed on a double wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_num_q <= '0;
			pos_a_q   <= 5'd1;
			pos_b_q   <= 4'd1;
			swap_q    <= 1'b0;
		end else if (cmd.cap) begin
			if (start_req) begin
				key_num_q <= file_size[8:2];
				pos_b_q   <= mod_const(file_size[8:2], MUL_9, SH_9, 4'd9) + 4'd1;
				swap_q    <= 1'b0;
			end
		end else if (cmd.xform) begin
			if (dbl_wrap) begin
				key_num_q <= key_num_inc;
				swap_q    <= ~swap_q;
				if (swap_q) begin
					pos_a_q <= 5'(mod_const(key_num_inc, MUL_12, SH_12, 4'd12)) + 5'd6;
					pos_b_q <= mod_const(key_num_inc, MUL_5, SH_5, 4'd5) + 4'd4;
				end else begin
					pos_a_q <= 5'(mod_const(key_num_inc, MUL_15, SH_15, 4'd15)) + 5'd3;
					pos_b_q <= mod_const(key_num_inc, MUL_7, SH_7, 4'd7) + 4'd1;
				end
			end else begin
				pos_a_q <= wrap_a ? 5'd1 : next_a;
				pos_b_q <= wrap_b ? 4'd1 : next_b[POS_B_W-1:0];
				swap_q  <= swap_q ^ wrap_a ^ wrap_b;
			end
		end else if (div_done) begin
			pos_a_q <= 5'(div_rem_next) + 5'd1;
		end
	end

	// Hold the accepted byte
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			data_q <= data_in;
			mode_q <= mode;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.xform) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.xform) data_out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;

	assign sts.div_done = div_done;
	assign sts.out_free = ~out_valid_q | out_ready;

endmodule

// ===== hdl/archive_byte_stream_cipher_top.sv =====
// Byte stream cipher for archive files. Each input transfer carries one byte,
// a mode (0 decrypt, 1 encrypt) and a start flag that, on the first byte of a
// file, seeds the key state from bits 8..2 of the file size. Every byte gives
// exactly one output byte. An ordinary byte is accepted and then transformed
// into the output register, which frees the input side so the next byte is
// taken while a result still waits. For a start byte, after the accept the
// bit-serial remainder unit is loaded and then run to find position A from
// key number mod position B, and then the transform cycle follows. A byte on
// which both key positions wrap costs nothing extra, since the new positions
// come from fixed-divisor remainders in the transform cycle. The transform
// cycle waits while an earlier result is still held and the output side is
// not ready. Load the key registers over the write port before streaming;
// they reset to zero.
module archive_byte_stream_cipher_top (
	input  logic                            clk,
	input  logic                            arst_n,
	absc_in_if.sink                         in_ch,
	absc_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [absc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [absc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import absc_pkg::*;

	absc_cmd_t cmd;
	absc_sts_t sts;

	absc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_start (in_ch.start_req),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	absc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.start_req (in_ch.start_req),
		.file_size (in_ch.file_size),
		.data_in   (in_ch.data_in),
		.mode      (in_ch.mode),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.data_out  (out_ch.data_out)
	);

endmodule
